/* hw/rtl/trab_pkg.sv */
// Shared types, constants and helper functions of the triangle raster blend block.
package trab_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int ADDR_W     = 16;
    localparam int DIM_W      = 9;
    localparam int COORD_W    = 8;
    localparam int VERT_W     = 16;
    localparam int EDGE_W     = 40;
    localparam int QDEPTH     = 2;
    localparam int QCNT_W     = 2;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TRI   = 2'd2;

    localparam logic [7:0] CFG_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_HEIGHT = 8'd1;

    typedef logic signed [EDGE_W-1:0] t_edge;

    typedef enum logic [2:0] {
        K_NOP,
        K_OOR,
        K_WRITE,
        K_READ,
        K_TRI
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [ADDR_W-1:0]      addr;
        logic [31:0]            value;
        logic [COORD_W-1:0]     minx;
        logic [COORD_W-1:0]     maxx;
        logic [COORD_W-1:0]     miny;
        logic [COORD_W-1:0]     maxy;
        logic [ADDR_W-1:0]      row_base;
        t_edge [2:0]            e;
        t_edge [2:0]            sx;
        t_edge [2:0]            sy;
    } t_cmd;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

    typedef enum logic [1:0] {
        F_IDLE,
        F_BOX,
        F_MUL,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_WALK,
        B_DRAIN
    } t_bstate;

    function automatic logic signed [VERT_W-1:0] min3(input logic signed [VERT_W-1:0] a,
                                                       input logic signed [VERT_W-1:0] b,
                                                       input logic signed [VERT_W-1:0] c);
        logic signed [VERT_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [VERT_W-1:0] max3(input logic signed [VERT_W-1:0] a,
                                                       input logic signed [VERT_W-1:0] b,
                                                       input logic signed [VERT_W-1:0] c);
        logic signed [VERT_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Drop the 4 fraction bits, rounding toward zero.
    function automatic logic signed [12:0] trunc_q4(input logic signed [VERT_W-1:0] v);
        logic signed [VERT_W:0] t;
        t = (VERT_W+1)'(v);
        if (v < 0) begin
            t = t + 17'sd15;
        end
        return 13'(t >>> 4);
    endfunction

    function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (v > DIM_W'(MAX_WIDTH)) begin
            return DIM_W'(MAX_WIDTH);
        end
        return v;
    endfunction

    function automatic logic [31:0] blend_word(input logic [31:0] dst, input logic [31:0] col);
        logic [7:0]  a;
        logic [16:0] t;
        logic [16:0] q;
        logic [31:0] res;
        a = col[31:24];
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            t = 17'(col[8*ch +: 8] * a) + 17'(dst[8*ch +: 8] * (8'd255 - a));
            // exact floor(t / 255) for t below 2^16
            q = (t + 17'd1 + (t >> 8)) >> 8;
            res[8*ch +: 8] = q[7:0];
        end
        res[31:24] = (dst[31:24] > a) ? dst[31:24] : a;
        return res;
    endfunction

endpackage

/* hw/rtl/triangle_raster_alpha_blend.sv */
// Top level of the triangle rasterizer with alpha blending over an RGBA frame store.
//
// Request channel (i_valid / o_ready) carries one operation: write pixel, read
// pixel or draw a filled triangle. Every request yields exactly one response
// on (o_valid / i_ready): read data for a read, zero otherwise, plus the
// out-of-range flag for pixel accesses. Responses come back in request order.
// The front end takes a request, classifies it and sets up the triangle edges
// in its F_BOX and F_MUL states; a 2-entry command queue feeds the back end,
// which owns the 64K x 32 frame store. A write or out-of-range access answers
// in the cycle after it leaves the queue; a read first passes through B_READ.
// A triangle walks its clamped bounding box one pixel per cycle (read, blend,
// write pipelined). The front end takes no new request until it has pushed the
// last one into the queue; for triangles the box walk sets the rate.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready: index 0 sets the
// image width, index 1 the height; other indexes are ignored.
// Synchronous reset sets width and height to 256 and empties the queue; the
// frame store is not cleared. A stalled receiver holds the response register;
// the queue and the front end keep taking requests until the queue fills.
module triangle_raster_alpha_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_op,
    input  logic [7:0]          i_pixel_x,
    input  logic [7:0]          i_pixel_y,
    input  logic [31:0]         i_pixel_value,
    input  logic signed [15:0]  i_vertex0_x,
    input  logic signed [15:0]  i_vertex0_y,
    input  logic signed [15:0]  i_vertex1_x,
    input  logic signed [15:0]  i_vertex1_y,
    input  logic signed [15:0]  i_vertex2_x,
    input  logic signed [15:0]  i_vertex2_y,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_read_data,
    output logic                o_out_of_range,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data
);
    import trab_pkg::*;

    logic [DIM_W-1:0] r_image_width, r_image_height;
    logic [DIM_W-1:0] eff_w, eff_h;
    logic             push, pop;
    t_cmd             cmd_in, cmd_out;
    t_q_stat          q_stat;

    assign o_cfg_ready = 1'b1;
    assign eff_w = eff_size(r_image_width);
    assign eff_h = eff_size(r_image_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_W'(MAX_WIDTH);
            r_image_height <= DIM_W'(MAX_HEIGHT);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_WIDTH)  r_image_width  <= i_cfg_data;
            if (i_cfg_index == CFG_HEIGHT) r_image_height <= i_cfg_data;
        end
    end

    trab_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_pixel_value (i_pixel_value),
        .i_vertex0_x   (i_vertex0_x),
        .i_vertex0_y   (i_vertex0_y),
        .i_vertex1_x   (i_vertex1_x),
        .i_vertex1_y   (i_vertex1_y),
        .i_vertex2_x   (i_vertex2_x),
        .i_vertex2_y   (i_vertex2_y),
        .i_width       (eff_w),
        .i_height      (eff_h),
        .i_full        (q_stat.full),
        .o_push        (push),
        .o_cmd         (cmd_in)
    );

    trab_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_stat  (q_stat)
    );

    trab_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_width        (eff_w),
        .i_cmd          (cmd_out),
        .i_empty        (q_stat.empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_read_data    (o_read_data),
        .o_out_of_range (o_out_of_range)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= QCNT_W'(QDEPTH))
        else $error("queue count overflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> q_stat.count == $past(q_stat.count) + QCNT_W'(1))
        else $error("queue count lost a push");

endmodule

/* hw/rtl/trab_front.sv */
// Front end: accepts requests, classifies them and prepares triangle setup.
module trab_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_op,
    input  logic [7:0]              i_pixel_x,
    input  logic [7:0]              i_pixel_y,
    input  logic [31:0]             i_pixel_value,
    input  logic signed [15:0]      i_vertex0_x,
    input  logic signed [15:0]      i_vertex0_y,
    input  logic signed [15:0]      i_vertex1_x,
    input  logic signed [15:0]      i_vertex1_y,
    input  logic signed [15:0]      i_vertex2_x,
    input  logic signed [15:0]      i_vertex2_y,
    input  logic [trab_pkg::DIM_W-1:0] i_width,
    input  logic [trab_pkg::DIM_W-1:0] i_height,
    input  logic                    i_full,
    output logic                    o_push,
    output trab_pkg::t_cmd          o_cmd
);
    import trab_pkg::*;

    t_fstate r_state, n_state;

    logic [1:0]               r_op;
    logic [COORD_W-1:0]       r_px, r_py;
    logic [31:0]              r_val;
    logic signed [VERT_W-1:0] r_vx [3];
    logic signed [VERT_W-1:0] r_vy [3];

    t_kind                    r_kind;
    logic [ADDR_W-1:0]        r_addr;
    logic [COORD_W-1:0]       r_minx, r_maxx, r_miny, r_maxy;
    logic [ADDR_W-1:0]        r_row_base;
    logic signed [16:0]       r_dx [3];
    logic signed [16:0]       r_dy [3];
    logic signed [17:0]       r_pxa [3];
    logic signed [17:0]       r_pya [3];
    logic signed [34:0]       r_m1 [3];
    logic signed [34:0]       r_m2 [3];

    logic signed [12:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [12:0] wm1, hm1;
    logic               box_empty;
    t_kind              kind_c;

    always_comb begin
        wm1 = $signed({4'b0, i_width}) - 13'sd1;
        hm1 = $signed({4'b0, i_height}) - 13'sd1;
        lo_x = trunc_q4(min3(r_vx[0], r_vx[1], r_vx[2]));
        hi_x = trunc_q4(max3(r_vx[0], r_vx[1], r_vx[2]));
        lo_y = trunc_q4(min3(r_vy[0], r_vy[1], r_vy[2]));
        hi_y = trunc_q4(max3(r_vy[0], r_vy[1], r_vy[2]));
        if (lo_x < 0) lo_x = '0;
        if (lo_y < 0) lo_y = '0;
        if (hi_x > wm1) hi_x = wm1;
        if (hi_y > hm1) hi_y = hm1;
        box_empty = (lo_x > hi_x) || (lo_y > hi_y);

        unique case (r_op)
            OP_WRITE, OP_READ: begin
                if ({1'b0, r_px} >= i_width || {1'b0, r_py} >= i_height) begin
                    kind_c = K_OOR;
                end else begin
                    kind_c = (r_op == OP_WRITE) ? K_WRITE : K_READ;
                end
            end
            OP_TRI: begin
                kind_c = (box_empty || r_val[31:24] == 8'd0) ? K_NOP : K_TRI;
            end
            default: kind_c = K_NOP;
        endcase
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = F_BOX;
            end
            F_BOX:  n_state = F_MUL;
            F_MUL:  n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_op    <= i_op;
            r_px    <= i_pixel_x;
            r_py    <= i_pixel_y;
            r_val   <= i_pixel_value;
            r_vx[0] <= i_vertex0_x;
            r_vy[0] <= i_vertex0_y;
            r_vx[1] <= i_vertex1_x;
            r_vy[1] <= i_vertex1_y;
            r_vx[2] <= i_vertex2_x;
            r_vy[2] <= i_vertex2_y;
        end
        if (r_state == F_BOX) begin
            r_kind <= kind_c;
            r_addr <= 16'(r_py * i_width) + {8'b0, r_px};
            r_minx <= lo_x[COORD_W-1:0];
            r_maxx <= hi_x[COORD_W-1:0];
            r_miny <= lo_y[COORD_W-1:0];
            r_maxy <= hi_y[COORD_W-1:0];
            for (int k = 0; k < 3; k++) begin
                r_dx[k]  <= 17'(r_vx[(k == 2) ? 0 : k + 1]) - 17'(r_vx[k]);
                r_dy[k]  <= 17'(r_vy[(k == 2) ? 0 : k + 1]) - 17'(r_vy[k]);
                r_pxa[k] <= $signed({6'b0, lo_x[COORD_W-1:0], 4'b1000}) - 18'(r_vx[k]);
                r_pya[k] <= $signed({6'b0, lo_y[COORD_W-1:0], 4'b1000}) - 18'(r_vy[k]);
            end
        end
        if (r_state == F_MUL) begin
            r_row_base <= 16'(r_miny * i_width);
            for (int k = 0; k < 3; k++) begin
                r_m1[k] <= r_dx[k] * r_pya[k];
                r_m2[k] <= r_dy[k] * r_pxa[k];
            end
        end
    end

    always_comb begin
        o_cmd.kind     = r_kind;
        o_cmd.addr     = r_addr;
        o_cmd.value    = r_val;
        o_cmd.minx     = r_minx;
        o_cmd.maxx     = r_maxx;
        o_cmd.miny     = r_miny;
        o_cmd.maxy     = r_maxy;
        o_cmd.row_base = r_row_base;
        for (int k = 0; k < 3; k++) begin
            o_cmd.e[k]  = EDGE_W'(r_m1[k]) - EDGE_W'(r_m2[k]);
            o_cmd.sx[k] = -(EDGE_W'(r_dy[k]) <<< 4);
            o_cmd.sy[k] = EDGE_W'(r_dx[k]) <<< 4;
        end
    end

endmodule

/* hw/rtl/trab_queue.sv */
// Short command queue between the front end and the back end.
module trab_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  trab_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output trab_pkg::t_cmd   o_cmd,
    output trab_pkg::t_q_stat o_stat
);
    import trab_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic              r_wp, r_rp;
    logic [QCNT_W-1:0] r_count;

    assign o_cmd        = r_mem[r_rp];
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

endmodule

/* hw/rtl/trab_back.sv */
// Back end: frame store, pixel access and the triangle walk with blending.
module trab_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [trab_pkg::DIM_W-1:0] i_width,
    input  trab_pkg::t_cmd             i_cmd,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [31:0]                o_read_data,
    output logic                       o_out_of_range
);
    import trab_pkg::*;

    logic [31:0] mem [MAX_WIDTH*MAX_HEIGHT];
    logic [31:0] r_mem_q;

    t_bstate r_state, n_state;

    logic               r_out_valid;
    logic [31:0]        r_out_data;
    logic               r_out_oor;

    logic [COORD_W-1:0] r_x, r_minx, r_maxx, r_y, r_maxy;
    logic [ADDR_W-1:0]  r_row_base, r_addr;
    logic [31:0]        r_color;
    t_edge              r_e [3];
    t_edge              r_er [3];
    t_edge              r_sx [3];
    t_edge              r_sy [3];

    logic               r_p_valid;
    logic [ADDR_W-1:0]  r_p_addr;

    logic               out_free, out_load, out_oor;
    logic               rd_en, we, covered, row_end, last_pix;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic [31:0]        wr_data, out_data;
    logic               neg, pos;

    assign out_free       = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_read_data    = r_out_data;
    assign o_out_of_range = r_out_oor;

    always_comb begin
        neg = 1'b0;
        pos = 1'b0;
        for (int k = 0; k < 3; k++) begin
            neg = neg | (r_e[k] < 0);
            pos = pos | (r_e[k] > 0);
        end
        covered  = !(neg && pos);
        row_end  = (r_x == r_maxx);
        last_pix = row_end && (r_y == r_maxy);
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        out_load = 1'b0;
        out_data = '0;
        out_oor  = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = i_cmd.addr;
        we       = 1'b0;
        wr_addr  = i_cmd.addr;
        wr_data  = i_cmd.value;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        K_WRITE: begin
                            we       = 1'b1;
                            out_load = 1'b1;
                        end
                        K_READ: begin
                            rd_en   = 1'b1;
                            n_state = B_READ;
                        end
                        K_OOR: begin
                            out_load = 1'b1;
                            out_oor  = 1'b1;
                        end
                        K_TRI:   n_state = B_WALK;
                        default: out_load = 1'b1;
                    endcase
                end
            end
            B_READ: begin
                out_load = 1'b1;
                out_data = r_mem_q;
                n_state  = B_IDLE;
            end
            B_WALK: begin
                rd_en   = covered;
                rd_addr = r_addr;
                if (last_pix) n_state = B_DRAIN;
            end
            B_DRAIN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
        // blend the pixel fetched last cycle
        if (r_p_valid) begin
            we      = 1'b1;
            wr_addr = r_p_addr;
            wr_data = blend_word(r_mem_q, r_color);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_mem_q <= mem[rd_addr];
        if (we)    mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_p_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= (r_state == B_WALK) && covered;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= out_data;
            r_out_oor  <= out_oor;
        end
        r_p_addr <= r_addr;
        if (o_pop && i_cmd.kind == K_TRI) begin
            r_x        <= i_cmd.minx;
            r_minx     <= i_cmd.minx;
            r_maxx     <= i_cmd.maxx;
            r_y        <= i_cmd.miny;
            r_maxy     <= i_cmd.maxy;
            r_row_base <= i_cmd.row_base;
            r_addr     <= i_cmd.row_base + {8'b0, i_cmd.minx};
            r_color    <= i_cmd.value;
            for (int k = 0; k < 3; k++) begin
                r_e[k]  <= i_cmd.e[k];
                r_er[k] <= i_cmd.e[k];
                r_sx[k] <= i_cmd.sx[k];
                r_sy[k] <= i_cmd.sy[k];
            end
        end else if (r_state == B_WALK) begin
            if (row_end) begin
                r_x        <= r_minx;
                r_y        <= r_y + 8'd1;
                r_row_base <= r_row_base + 16'(i_width);
                r_addr     <= r_row_base + 16'(i_width) + {8'b0, r_minx};
                for (int k = 0; k < 3; k++) begin
                    r_er[k] <= r_er[k] + r_sy[k];
                    r_e[k]  <= r_er[k] + r_sy[k];
                end
            end else begin
                r_x    <= r_x + 8'd1;
                r_addr <= r_addr + 16'd1;
                for (int k = 0; k < 3; k++) begin
                    r_e[k] <= r_e[k] + r_sx[k];
                end
            end
        end
    end

endmodule
